>>> hw/rtl/kvt_pkg.sv
package kvt_pkg;

	// fixed widths of the word fields on the ports
	localparam int unsigned FIELD_W = 32;

	// defaults for the top level parameters
	localparam int unsigned DEPTH_DEF       = 16;
	localparam int unsigned KEY_WIDTH_DEF   = 32;
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	// request codes
	typedef enum logic [1:0] {
		REQ_GET  = 2'd0,
		REQ_PUT  = 2'd1,
		REQ_LIST = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	// one result word as it leaves the sequencer
	typedef struct packed {
		logic                 valid;
		status_t              status;
		logic [FIELD_W-1:0]   value;
		logic [FIELD_W-1:0]   key;
		logic                 last;
	} result_t;

endpackage

>>> hw/rtl/kvt_ram.sv
module kvt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/kvt_scan.sv
module kvt_scan #(
	parameter int unsigned DEPTH       = 16,
	parameter int unsigned KEY_WIDTH   = 32,
	parameter int unsigned VALUE_WIDTH = 32,
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [kvt_pkg::FIELD_W-1:0]   lookup_key,
	input  logic [kvt_pkg::FIELD_W-1:0]   store_value,
	// memory side, both stores share the addresses
	output logic                          rd_en,
	output logic [IDX_W-1:0]              rd_addr,
	input  logic [KEY_WIDTH-1:0]          key_rdata,
	input  logic [VALUE_WIDTH-1:0]        val_rdata,
	output logic                          key_we,
	output logic                          val_we,
	output logic [IDX_W-1:0]              wr_addr,
	output logic [KEY_WIDTH-1:0]          key_wdata,
	output logic [VALUE_WIDTH-1:0]        val_wdata,
	// result side
	output kvt_pkg::result_t              result
);

	import kvt_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	state_t                 state_q, state_d;
	req_t                   req_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]       issue_q;
	logic [CNT_W-1:0]       count_q;
	logic                   valid_s1;
	logic [IDX_W-1:0]       idx_s1;
	result_t                res_q, res_d;

	logic accept;
	logic is_lookup;
	logic hit;
	logic list_out;
	logic list_last;
	logic scan_end;
	logic finish;
	logic has_room;
	logic count_inc;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign has_room  = (count_q < CNT_W'(DEPTH));
	assign is_lookup = (req_q == REQ_GET) || (req_q == REQ_PUT);

	// compare stage, one entry behind the read, on the registered read data
	assign hit       = valid_s1 && is_lookup && (key_rdata == key_q);
	assign list_out  = valid_s1 && (req_q == REQ_LIST);
	assign list_last = (CNT_W'(idx_s1) + CNT_W'(1)) == count_q;
	assign scan_end  = (state_q == S_SCAN) && !valid_s1
		&& ((issue_q >= count_q) || (req_q == REQ_NONE));
	assign finish    = hit || (list_out && list_last) || scan_end;

	// read issue over the filled slots
	assign rd_en   = (state_q == S_SCAN) && (req_q != REQ_NONE)
		&& (issue_q < count_q) && !hit;
	assign rd_addr = issue_q[IDX_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (finish) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result word and store writes
	always_comb begin
		res_d        = '0;
		res_d.status = ST_OK;
		key_we       = 1'b0;
		val_we       = 1'b0;
		wr_addr      = idx_s1;
		key_wdata    = key_q;
		val_wdata    = val_q;
		count_inc    = 1'b0;
		priority if (hit) begin
			res_d.valid = 1'b1;
			res_d.last  = 1'b1;
			if (req_q == REQ_GET) begin
				res_d.value = FIELD_W'(val_rdata);
			end else begin
				val_we = 1'b1;
			end
		end else if (list_out) begin
			res_d.valid = 1'b1;
			res_d.key   = FIELD_W'(key_rdata);
			res_d.last  = list_last;
		end else if (scan_end) begin
			res_d.valid = 1'b1;
			res_d.last  = 1'b1;
			unique case (req_q)
				REQ_GET:  res_d.status = ST_NOT_FOUND;
				REQ_PUT: begin
					if (has_room) begin
						key_we    = 1'b1;
						val_we    = 1'b1;
						wr_addr   = count_q[IDX_W-1:0];
						count_inc = 1'b1;
					end else begin
						res_d.status = ST_FULL;
					end
				end
				REQ_LIST: res_d.status = ST_EMPTY;
				REQ_NONE: res_d.status = ST_NOT_FOUND;
				default:  res_d.status = ST_NOT_FOUND;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			issue_q   <= '0;
			count_q   <= '0;
			valid_s1  <= 1'b0;
			res_q     <= '0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= rd_en;
			res_q    <= res_d;
			if (accept) begin
				issue_q <= '0;
			end else if (rd_en) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			if (count_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// request word and read index
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_t'(req_type);
			key_q <= KEY_WIDTH'(lookup_key);
			val_q <= VALUE_WIDTH'(store_value);
		end
		if (rd_en) begin
			idx_s1 <= rd_addr;
		end
	end

	assign result = res_q;

endmodule

>>> hw/rtl/key_value_table_top.sv
// key/value table with up to DEPTH pairs kept in insertion order
//
// request channel: a word is taken at a rising edge with start high and busy
// low. req_type selects get (value for lookup_key), put (store store_value
// under lookup_key, overwrite or append) or list (every stored key in order).
// result channel: each result word is on the ports for one cycle with
// result_valid high; the receiver cannot stall, so results are never held.
// every request ends with one word that has last set; list gives one word
// per stored key, back to back, or a single empty-status word.
//
// timing: the stores are read one slot a cycle from slot 0, with the compare
// on the registered read data in the cycle after. busy holds while slots
// are read, and when a get or put misses it also waits out the last compare;
// a hit stops at the matching slot, a list reads every filled slot, and a
// request on an empty table or with the unused code reads no slot. a result
// passes the store read register and the result register before it is on
// the ports; busy drops as the final word is registered.
//
// reset clears the fill count, so the table starts empty; store contents
// are not cleared and are never read before they are written.
module key_value_table_top #(
	parameter int unsigned DEPTH       = kvt_pkg::DEPTH_DEF,
	parameter int unsigned KEY_WIDTH   = kvt_pkg::KEY_WIDTH_DEF,
	parameter int unsigned VALUE_WIDTH = kvt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic [kvt_pkg::FIELD_W-1:0] lookup_key,
	input  logic [kvt_pkg::FIELD_W-1:0] store_value,
	output logic                        result_valid,
	output logic [1:0]                  status,
	output logic [kvt_pkg::FIELD_W-1:0] value_out,
	output logic [kvt_pkg::FIELD_W-1:0] key_out,
	output logic                        last
);

	import kvt_pkg::*;

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic [KEY_WIDTH-1:0]   key_rdata;
	logic [VALUE_WIDTH-1:0] val_rdata;
	logic                   key_we;
	logic                   val_we;
	logic [IDX_W-1:0]       wr_addr;
	logic [KEY_WIDTH-1:0]   key_wdata;
	logic [VALUE_WIDTH-1:0] val_wdata;
	result_t                result;

	// scan sequencer
	kvt_scan #(
		.DEPTH       (DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.lookup_key  (lookup_key),
		.store_value (store_value),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.key_rdata   (key_rdata),
		.val_rdata   (val_rdata),
		.key_we      (key_we),
		.val_we      (val_we),
		.wr_addr     (wr_addr),
		.key_wdata   (key_wdata),
		.val_wdata   (val_wdata),
		.result      (result)
	);

	// key store
	kvt_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (wr_addr),
		.wdata (key_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (key_rdata)
	);

	// value store
	kvt_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (DEPTH)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (wr_addr),
		.wdata (val_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	// result word onto the ports
	assign result_valid = result.valid;
	assign status       = result.status;
	assign value_out    = result.value;
	assign key_out      = result.key;
	assign last         = result.last;

endmodule

>>> hw/rtl/kvt_checker.sv
module kvt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        result_valid,
	input logic [1:0]                  status,
	input logic [kvt_pkg::FIELD_W-1:0] value_out,
	input logic [kvt_pkg::FIELD_W-1:0] key_out,
	input logic                        last
);

	import kvt_pkg::*;

	// an accepted request keeps the block busy in the next cycle
	ap_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but busy not raised");

	// any status other than ok ends the request
	ap_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status != ST_OK)) |-> last)
		else $error("error status without last");

	// list words come back to back until the last one
	ap_list_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |=> result_valid)
		else $error("gap inside a list burst");

	// the block stays busy while a list burst is still running
	ap_burst_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |-> busy)
		else $error("not busy inside a list burst");

	// a value is only returned on a hit and never beside a key
	ap_value_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (value_out != '0)) |-> ((status == ST_OK) && (key_out == '0)))
		else $error("value returned outside a get hit");

endmodule

bind key_value_table_top kvt_checker u_kvt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.status       (status),
	.value_out    (value_out),
	.key_out      (key_out),
	.last         (last)
);
